// ===== sv/bitmap_page_allocator_macros.svh =====
// assertion macros shared by the bitmap page allocator rtl
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define BPA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bitmap page allocator check failed");

// condition must never be seen outside reset
`define BPA_ASSERT_NEVER(label, clk, rst_n, cond) \
  `BPA_ASSERT(label, clk, rst_n, !(cond))

`else

`define BPA_ASSERT(label, clk, rst_n, prop)
`define BPA_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== sv/bpa_pkg.sv =====
// types, constants and helpers of the bitmap page allocator
package bpa_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned WordSelW  = 5;
  localparam int unsigned PageW     = 12;
  localparam int unsigned CfgW      = 13;
  localparam int unsigned FuncW     = 2;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned DataW     = 16;

  localparam logic [CfgW-1:0] PageCountReset = 13'd4096;

  typedef enum logic [FuncW-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_PEEK  = 2'd2
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_RANGE   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_FREE_RD,
    S_FREE_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_INC,
    PTR_HINT,
    PTR_IDX
  } ptr_op_e;

  typedef enum logic [1:0] {
    WR_ZERO,
    WR_SET,
    WR_CLR
  } wr_sel_e;

  typedef enum logic [1:0] {
    RES_FOUND,
    RES_NOFREE,
    RES_RANGE,
    RES_OK
  } res_sel_e;

  typedef struct packed {
    ptr_op_e  ptr_op;
    logic     mem_rd;
    logic     mem_wr;
    wr_sel_e  wr_sel;
    logic     req_load;
    logic     res_load;
    res_sel_e res_sel;
    logic     hint_alloc;
    logic     hint_free;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic             idx_in_range;
    logic             ptr_last;
    logic             scan_end;
    logic             word_has_zero;
    logic             found_in_range;
    logic             out_free;
  } sts_t;

  // position of the lowest clear bit, zero when the word is full
  function automatic logic [WordSelW-1:0] lowest_zero(input logic [WordBits-1:0] word);
    logic [WordSelW-1:0] pos;
    pos = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (!word[i]) begin
        pos = WordSelW'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== sv/bitmap_page_allocator.sv =====
// top level of the bitmap first-fit page allocator
// First-fit physical page allocator with one used bit per page, kept in a
// single-port memory of 32-bit words (ceil(MAX_PAGES/32) words). Each request
// beat carries a func in tuser (allocate, free, peek) and, for free, a page
// index in tdata. Allocate returns the lowest free page below the page count
// and marks it used; peek returns the same page and changes nothing; free
// releases a page. Each request yields exactly one result beat with the page
// in tdata and a status in tuser (ok, no free page, index out of range).
// After reset the block sweeps the bitmap clear, one word per cycle, with
// s_axis_tready low; the page count register can be written during that
// time. Requests are handled one at a time.
// A free reads the word that holds the page and writes it back with the bit
// cleared; an index out of range and a func value with no meaning go
// straight to the result. Allocate and peek read and check the bitmap words
// in turn until one has a clear bit or the scan passes the page count. The
// scan rate is set by the single memory read port (read, then check a
// word). The scan starts at a hint word below which all pages are known to
// be used, so it usually reads only one or two words.
// The result sits in an output register, so the next request is accepted
// while it waits.
module bitmap_page_allocator #(
  parameter int unsigned MAX_PAGES = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // page count register
  input  logic                        cfg_we_i,
  input  logic [bpa_pkg::CfgW-1:0]    cfg_wdata_i,
  // request stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [bpa_pkg::DataW-1:0]   s_axis_tdata,   // [11:0] page_index, [15:12] zero
  input  logic [bpa_pkg::FuncW-1:0]   s_axis_tuser,   // [1:0] func
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [bpa_pkg::DataW-1:0]   m_axis_tdata,   // [11:0] page_out, [15:12] zero
  output logic [bpa_pkg::StatusW-1:0] m_axis_tuser    // [1:0] status
);
  import bpa_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [PageW-1:0] page_out;

  // sequencer: clear sweep, decode, bitmap scan and read-modify-write
  bpa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // bitmap memory, pointers and the result beat register
  bpa_datapath #(
    .MAX_PAGES (MAX_PAGES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_idx_i   (s_axis_tdata[PageW-1:0]),
    .req_func_i  (s_axis_tuser),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_page_o    (page_out),
    .m_status_o  (m_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // pad the page number to whole bytes
  assign m_axis_tdata = DataW'(page_out);

endmodule

// ===== sv/bpa_ctrl.sv =====
// request sequencer of the bitmap page allocator
module bpa_ctrl (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  bpa_pkg::sts_t sts_i,
  output bpa_pkg::cmd_t cmd_o
);
  import bpa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.mem_wr = 1'b1;
        cmd_o.wr_sel = WR_ZERO;
        if (sts_i.ptr_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.ptr_op = PTR_INC;
        end
      end
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.func)
          FUNC_ALLOC, FUNC_PEEK: begin
            cmd_o.ptr_op = PTR_HINT;
            state_d      = S_SCAN_RD;
          end
          FUNC_FREE: begin
            if (sts_i.idx_in_range) begin
              cmd_o.ptr_op = PTR_IDX;
              state_d      = S_FREE_RD;
            end else begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RES_RANGE;
              state_d        = S_DONE;
            end
          end
          default: begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = RES_OK;
            state_d        = S_DONE;
          end
        endcase
      end
      S_FREE_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd_o.mem_wr    = 1'b1;
        cmd_o.wr_sel    = WR_CLR;
        cmd_o.hint_free = 1'b1;
        cmd_o.res_load  = 1'b1;
        cmd_o.res_sel   = RES_OK;
        state_d         = S_DONE;
      end
      S_SCAN_RD: begin
        if (sts_i.scan_end) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_NOFREE;
          state_d        = S_DONE;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d      = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        priority if (sts_i.word_has_zero && sts_i.found_in_range) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_FOUND;
          if (sts_i.func == FUNC_ALLOC) begin
            cmd_o.mem_wr     = 1'b1;
            cmd_o.wr_sel     = WR_SET;
            cmd_o.hint_alloc = 1'b1;
          end
          state_d = S_DONE;
        end else if (sts_i.word_has_zero) begin
          // lowest clear bit lies at or above the page count
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_NOFREE;
          state_d        = S_DONE;
        end else begin
          cmd_o.ptr_op = PTR_INC;
          state_d      = S_SCAN_RD;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/bpa_datapath.sv =====
// bitmap memory, scan pointer, free-word hint and result register
`include "bitmap_page_allocator_macros.svh"

module bpa_datapath #(
  parameter int unsigned MAX_PAGES = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bpa_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic [bpa_pkg::PageW-1:0]    req_idx_i,
  input  logic [bpa_pkg::FuncW-1:0]    req_func_i,
  input  logic                         m_ready_i,
  output logic                         m_valid_o,
  output logic [bpa_pkg::PageW-1:0]    m_page_o,
  output logic [bpa_pkg::StatusW-1:0]  m_status_o,
  input  bpa_pkg::cmd_t                cmd_i,
  output bpa_pkg::sts_t                sts_o
);
  import bpa_pkg::*;

  localparam int unsigned NWords = (MAX_PAGES + WordBits - 1) / WordBits;
  localparam int unsigned AddrW  = (NWords > 1) ? $clog2(NWords) : 1;
  localparam int unsigned PtrW   = AddrW + 1;
  localparam int unsigned MaxW   = $clog2(MAX_PAGES + 1);
  localparam int unsigned CntW   = (MaxW > CfgW) ? MaxW : CfgW;
  localparam int unsigned CmpW   = (CntW > PtrW + WordSelW) ? CntW : PtrW + WordSelW;

  logic [WordBits-1:0] mem_q [NWords];
  logic [WordBits-1:0] rdata_q;
  logic [WordBits-1:0] wdata;
  logic [WordBits-1:0] set_word;

  logic [CfgW-1:0]     page_count_q;
  logic [PtrW-1:0]     ptr_q, ptr_d;
  logic [PtrW-1:0]     hint_q, hint_d;
  logic [FuncW-1:0]    func_q;
  logic [PageW-1:0]    idx_q;
  logic [PageW-1:0]    res_page_q, res_page_d;
  logic [StatusW-1:0]  res_status_q, res_status_d;
  logic                out_valid_q;
  logic [PageW-1:0]    out_page_q;
  logic [StatusW-1:0]  out_status_q;

  logic [CntW-1:0]     count_ext;
  logic [CmpW-1:0]     active;
  logic [CmpW-1:0]     idx_ext;
  logic [CmpW-1:0]     base;
  logic [CmpW-1:0]     found;
  logic [PtrW-1:0]     idx_word;
  logic [WordSelW-1:0] zero_pos;

  // active page count, saturated at the map size
  assign count_ext = CntW'(page_count_q);
  assign active    = (count_ext > CntW'(MAX_PAGES)) ? CmpW'(MAX_PAGES) : CmpW'(count_ext);

  assign idx_ext  = CmpW'(idx_q);
  assign idx_word = PtrW'(idx_ext >> WordSelW);
  assign base     = CmpW'({ptr_q, WordSelW'(0)});
  assign zero_pos = lowest_zero(rdata_q);
  assign found    = CmpW'({ptr_q[AddrW-1:0], zero_pos});
  assign set_word = rdata_q | (WordBits'(1) << zero_pos);

  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_SET:  wdata = set_word;
      WR_CLR:  wdata = rdata_q & ~(WordBits'(1) << idx_q[WordSelW-1:0]);
      default: wdata = '0;
    endcase
  end

  // single-port bitmap, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem_q[ptr_q[AddrW-1:0]] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem_q[ptr_q[AddrW-1:0]];
    end
  end

  always_comb begin
    unique case (cmd_i.ptr_op)
      PTR_INC:  ptr_d = ptr_q + PtrW'(1);
      PTR_HINT: ptr_d = hint_q;
      PTR_IDX:  ptr_d = idx_word;
      default:  ptr_d = ptr_q;
    endcase
  end

  // words below the hint are known to be fully used
  always_comb begin
    hint_d = hint_q;
    priority if (cmd_i.hint_alloc) begin
      hint_d = (&set_word) ? ptr_q + PtrW'(1) : ptr_q;
    end else if (cmd_i.hint_free && (ptr_q < hint_q)) begin
      hint_d = ptr_q;
    end else begin
      hint_d = hint_q;
    end
  end

  always_comb begin
    res_page_d   = '0;
    res_status_d = STAT_OK;
    unique case (cmd_i.res_sel)
      RES_FOUND:  res_page_d   = found[PageW-1:0];
      RES_NOFREE: res_status_d = STAT_NO_FREE;
      RES_RANGE:  res_status_d = STAT_RANGE;
      default:    res_status_d = STAT_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_count_q <= PageCountReset;
      ptr_q        <= '0;
      hint_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        page_count_q <= cfg_wdata_i;
      end
      ptr_q  <= ptr_d;
      hint_q <= hint_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      func_q <= req_func_i;
      idx_q  <= req_idx_i;
    end
    if (cmd_i.res_load) begin
      res_page_q   <= res_page_d;
      res_status_q <= res_status_d;
    end
    if (cmd_i.out_load) begin
      out_page_q   <= res_page_q;
      out_status_q <= res_status_q;
    end
  end

  assign m_valid_o  = out_valid_q;
  assign m_page_o   = out_page_q;
  assign m_status_o = out_status_q;

  assign sts_o.func           = func_q;
  assign sts_o.idx_in_range   = idx_ext < active;
  assign sts_o.ptr_last       = ptr_q == PtrW'(NWords - 1);
  assign sts_o.scan_end       = (ptr_q >= PtrW'(NWords)) || (base >= active);
  assign sts_o.word_has_zero  = ~&rdata_q;
  assign sts_o.found_in_range = found < active;
  assign sts_o.out_free       = !out_valid_q || m_ready_i;

  `BPA_ASSERT(a_ptr_bound, clk_i, rst_ni, ptr_q <= PtrW'(NWords))
  `BPA_ASSERT(a_hint_bound, clk_i, rst_ni, hint_q <= PtrW'(NWords))
  `BPA_ASSERT(a_set_only_free_bit, clk_i, rst_ni, (cmd_i.mem_wr && cmd_i.wr_sel == WR_SET) |-> (sts_o.word_has_zero && sts_o.found_in_range))
  `BPA_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd_i.out_load && out_valid_q && !m_ready_i)

endmodule
